// ----- rtl/assert_macros.svh -----
// Assertion macros used by the LRU tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/lrut_pkg.sv -----
// Types, codes and sizes for the LRU entry tracker.
package lrut_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 16;
  localparam int IDX_BITS = $clog2(SLOTS);
  localparam int CNT_BITS = $clog2(SLOTS + 1);
  localparam int OCC_BITS = 5;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_TAKE   = 3'd1;
  localparam logic [2:0] MODE_GET    = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_PRUNE  = 3'd4;

  localparam logic [2:0] STAT_EVICT = 3'd0;
  localparam logic [2:0] STAT_DONE  = 3'd1;
  localparam logic [2:0] STAT_HIT   = 3'd2;
  localparam logic [2:0] STAT_MISS  = 3'd3;
  localparam logic [2:0] STAT_EXPD  = 3'd4;

  typedef struct packed {
    logic [2:0]          mode;
    logic [KEY_BITS-1:0] item_key;
    logic                expired;
    logic [OCC_BITS-1:0] limit;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_BITS-1:0] result_key;
    logic [OCC_BITS-1:0] occupancy_now;
    logic                last;
  } out_t;

endpackage

// ----- rtl/lru_entry_tracker_with_capacity.sv -----
// LRU key tracker with capacity limit: key scan, recency ranks and eviction sequencer.
// Key scan reads one slot per cycle with one compare; take, get, remove and spare modes then
//   load their final result. Add first checks capacity and inserts; prune trims occupancy
//   to its limit or the capacity; every eviction reads key memory, then drops the entry.
// Throughput: one request at a time; in_stall stays high until its final result is loaded.
// Reset (synchronous, active low) clears valid bits, ranks, occupancy, capacity; not key memory.
`include "assert_macros.svh"
module lru_entry_tracker_with_capacity import lrut_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OCC_BITS-1:0] cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_ACT   = 8'b0000_0100,
    ST_ADD   = 8'b0000_1000,
    ST_INS   = 8'b0001_0000,
    ST_EVICT = 8'b0010_0000,
    ST_EVRD  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  in_t                 req_r;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [IDX_BITS-1:0] rd_idx_r;
  logic [KEY_BITS-1:0] rd_key_r;
  logic                hit_r, hit_nxt;
  logic [IDX_BITS-1:0] hit_idx_r, hit_idx_nxt;
  logic [OCC_BITS-1:0] target_r, target_nxt;
  logic                pend_ins_r, pend_ins_nxt;
  logic [2:0]          fin_status_r, fin_status_nxt;
  logic [IDX_BITS-1:0] lru_idx_r, lru_idx_nxt;
  logic [OCC_BITS-1:0] occ_r;
  logic [OCC_BITS-1:0] cap_r;
  logic [SLOTS-1:0]    slot_valid_r;
  logic [IDX_BITS-1:0] slot_rank_r [SLOTS];
  logic [KEY_BITS-1:0] key_mem [SLOTS];
  logic                out_valid_r;
  out_t                out_data_r;

  logic [OCC_BITS-1:0] cap_eff;
  logic [OCC_BITS-1:0] occ_m1;
  logic                out_free;
  logic                in_xfer;
  logic [IDX_BITS-1:0] free_idx;
  logic [IDX_BITS-1:0] lru_idx;
  logic                rd_en;
  logic [IDX_BITS-1:0] rd_addr;
  logic                drop_en;
  logic [IDX_BITS-1:0] drop_idx;
  logic [IDX_BITS-1:0] drop_rank;
  logic                ins_en;
  logic                emit;
  out_t                emit_data;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cap_eff   = (cap_r > OCC_BITS'(SLOTS)) ? OCC_BITS'(SLOTS) : cap_r;
  assign occ_m1    = OCC_BITS'(occ_r - 1'b1);
  assign drop_rank = slot_rank_r[drop_idx];

  always_comb begin
    free_idx = '0;
    lru_idx  = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!slot_valid_r[j]) begin
        free_idx = IDX_BITS'(j);
      end
      if (slot_valid_r[j] && slot_rank_r[j] == occ_m1[IDX_BITS-1:0]) begin
        lru_idx = IDX_BITS'(j);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    target_nxt     = target_r;
    pend_ins_nxt   = pend_ins_r;
    fin_status_nxt = fin_status_r;
    lru_idx_nxt    = lru_idx_r;
    rd_en          = 1'b0;
    rd_addr        = cnt_r[IDX_BITS-1:0];
    drop_en        = 1'b0;
    drop_idx       = hit_idx_r;
    ins_en         = 1'b0;
    emit           = 1'b0;
    emit_data      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r && !hit_r && slot_valid_r[rd_idx_r] && rd_key_r == req_r.item_key) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end
        if (cnt_r < CNT_BITS'(SLOTS)) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          cnt_nxt    = CNT_BITS'(cnt_r + 1'b1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        fin_status_nxt = STAT_DONE;
        state_nxt      = ST_FIN;
        unique case (req_r.mode)
          MODE_ADD: begin
            drop_en   = hit_r;
            state_nxt = ST_ADD;
          end
          MODE_TAKE: begin
            drop_en        = hit_r;
            fin_status_nxt = !hit_r ? STAT_MISS : (req_r.expired ? STAT_EXPD : STAT_HIT);
          end
          MODE_GET: begin
            drop_en        = hit_r && req_r.expired;
            fin_status_nxt = !hit_r ? STAT_MISS : (req_r.expired ? STAT_EXPD : STAT_HIT);
          end
          MODE_REMOVE: begin
            drop_en = hit_r;
          end
          MODE_PRUNE: begin
            target_nxt   = (req_r.limit < cap_eff) ? req_r.limit : cap_eff;
            pend_ins_nxt = 1'b0;
            state_nxt    = ST_EVICT;
          end
          default: begin
          end
        endcase
      end
      ST_ADD: begin
        if (cap_eff == '0) begin
          target_nxt   = '0;
          pend_ins_nxt = 1'b0;
          state_nxt    = ST_EVICT;
        end else if (occ_r >= OCC_BITS'(SLOTS)) begin
          target_nxt   = OCC_BITS'(SLOTS - 1);
          pend_ins_nxt = 1'b1;
          state_nxt    = ST_EVICT;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        ins_en       = 1'b1;
        target_nxt   = cap_eff;
        pend_ins_nxt = 1'b0;
        state_nxt    = ST_EVICT;
      end
      ST_EVICT: begin
        if (occ_r > target_r) begin
          rd_en       = 1'b1;
          rd_addr     = lru_idx;
          lru_idx_nxt = lru_idx;
          state_nxt   = ST_EVRD;
        end else if (pend_ins_r) begin
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_EVRD: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data.status        = STAT_EVICT;
          emit_data.result_key    = rd_key_r;
          emit_data.occupancy_now = occ_m1;
          emit_data.last          = 1'b0;
          drop_en                 = 1'b1;
          drop_idx                = lru_idx_r;
          state_nxt               = ST_EVICT;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data.status        = fin_status_r;
          emit_data.result_key    = req_r.item_key;
          emit_data.occupancy_now = occ_r;
          emit_data.last          = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      pend_ins_r   <= 1'b0;
      occ_r        <= '0;
      cap_r        <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        slot_rank_r[j] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      hit_r      <= hit_nxt;
      pend_ins_r <= pend_ins_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (drop_en) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (IDX_BITS'(j) == drop_idx) begin
            slot_valid_r[j] <= 1'b0;
          end else if (slot_valid_r[j] && slot_rank_r[j] > drop_rank) begin
            slot_rank_r[j] <= IDX_BITS'(slot_rank_r[j] - 1'b1);
          end
        end
        if (occ_r != '0) begin
          occ_r <= occ_m1;
        end
      end else if (ins_en) begin
        for (int j = 0; j < SLOTS; j++) begin
          if (slot_valid_r[j]) begin
            slot_rank_r[j] <= IDX_BITS'(slot_rank_r[j] + 1'b1);
          end else if (IDX_BITS'(j) == free_idx) begin
            slot_valid_r[j] <= 1'b1;
            slot_rank_r[j]  <= '0;
          end
        end
        occ_r <= OCC_BITS'(occ_r + 1'b1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    hit_idx_r    <= hit_idx_nxt;
    target_r     <= target_nxt;
    fin_status_r <= fin_status_nxt;
    lru_idx_r    <= lru_idx_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      key_mem[free_idx] <= req_r.item_key;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
    end
  end

  `ASSERT_IMPLY(a_occ_range, 1'b1, occ_r <= OCC_BITS'(SLOTS))
  `ASSERT_IMPLY(a_occ_count, 1'b1, OCC_BITS'($countones(slot_valid_r)) == occ_r)
  `ASSERT_NEXT(a_fin_idle, state_r == ST_FIN && out_free, state_r == ST_IDLE && out_valid_r)
  `ASSERT_IMPLY(a_ins_room, ins_en, occ_r < OCC_BITS'(SLOTS))

endmodule
